// ===== rtl/spv_pkg.sv =====
// Shared constants, types and the semitone table of the sampler voice.
package spv_pkg;

	localparam int ADDR_BITS     = 16;
	localparam int SAMPLE_BITS   = 16;
	localparam int GUARD_SAMPLES = 4;
	localparam int MEM_DEPTH     = (1 << ADDR_BITS) + GUARD_SAMPLES;
	localparam int MEM_AW        = $clog2(MEM_DEPTH);
	localparam int FRAC_BITS     = 24;
	localparam int POS_W         = ADDR_BITS + 1 + FRAC_BITS;
	localparam int IDX_W         = POS_W - FRAC_BITS;
	localparam int MUL_W         = 26;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int BUS_W         = 24;
	localparam int CHAN_W        = 25;
	localparam int STEP_W        = 32;
	localparam int DIVISOR_W     = 17;
	localparam int RAMP_W        = 24;
	localparam int REL_W         = 25;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 24;
	localparam logic [RAMP_W-1:0] RAMP_UNITY = 24'd8388608;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROOT_NOTE     = 3'd0,
		REG_RATE_RATIO    = 3'd1,
		REG_SAMPLE_LENGTH = 3'd2,
		REG_RAMP_ON       = 3'd3,
		REG_RAMP_OFF      = 3'd4,
		REG_STEREO_SOURCE = 3'd5,
		REG_STEREO_OUT    = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_LOAD     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP_MUL,
		ST_STEP_RND,
		ST_ATK_GO,
		ST_ATK_WAIT,
		ST_REL_GO,
		ST_REL_WAIT,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_MA,
		ST_MB,
		ST_MG,
		ST_MR,
		ST_MD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [STEP_W-1:0]    dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	function automatic logic [23:0] semitone_q23(input logic [3:0] s);
		logic [23:0] v;
		case (s)
			4'd0:    v = 24'd8388608;
			4'd1:    v = 24'd8887421;
			4'd2:    v = 24'd9415894;
			4'd3:    v = 24'd9975792;
			4'd4:    v = 24'd10568984;
			4'd5:    v = 24'd11197448;
			4'd6:    v = 24'd11863283;
			4'd7:    v = 24'd12568711;
			4'd8:    v = 24'd13316085;
			4'd9:    v = 24'd14107901;
			4'd10:   v = 24'd14946800;
			4'd11:   v = 24'd15835583;
			default: v = 24'd8388608;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/spv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module spv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/spv_mul.sv =====
// Shared signed multiplier with a registered product.
module spv_mul (
	input  logic                              clk,
	input  logic signed [spv_pkg::MUL_W-1:0]  a,
	input  logic signed [spv_pkg::MUL_W-1:0]  b,
	output logic signed [spv_pkg::PROD_W-1:0] product
);
	import spv_pkg::*;

	logic signed [PROD_W-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= a * b;
	end

	assign product = product_q;

endmodule

// ===== rtl/spv_div.sv =====
// Radix-2 restoring divider that yields one quotient bit per cycle.
module spv_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spv_pkg::div_req_t              req,
	output logic                           done,
	output logic [spv_pkg::STEP_W-1:0]     quotient
);
	import spv_pkg::*;

	localparam int CNT_W = $clog2(STEP_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] den_q;
	logic [STEP_W-1:0]    quot_q;
	logic [DIVISOR_W:0]   trial;

	assign trial = {rem_q, quot_q[STEP_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(STEP_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEP_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= req.divisor;
			quot_q <= req.dividend;
		end else if (busy_q) begin
			// The dividend shifts out of the top while quotient bits shift in below.
			if (!trial[DIVISOR_W]) begin
				rem_q  <= trial[DIVISOR_W-1:0];
				quot_q <= {quot_q[STEP_W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[DIVISOR_W-2:0], quot_q[STEP_W-1]};
				quot_q <= {quot_q[STEP_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ===== rtl/sample_playback_voice_core.sv =====
// Top level of the sampler voice: sequencer, voice state and output register.
//
//  channel | direction | handshake           | payload
//  cfg     | in        | cfg_write           | cfg_index, cfg_data
//  in      | in        | in_valid, in_stall  | cmd, load_*, note, velocity, allow_tail, mix_*
//  out     | out       | out_valid, out_stall| out_left, out_right, voice_active
//
// A load or note-off leaves the sequencer idle. A note-on works out the step, then
// has the divider work out each ramp step that is enabled. A render tick on a playing
// voice reads both taps and runs the multiply steps for left, and again for right when
// the right channel is read; the shared multiplier and one memory read port serialise it.
// Reset clears the voice state; the sample memory keeps no reset value.
// A finished tick waits in its final step while the previous result is stalled.
module sample_playback_voice_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [spv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spv_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [16:0]                         load_addr,
	input  logic signed [15:0]                  load_left,
	input  logic signed [15:0]                  load_right,
	input  logic [6:0]                          note,
	input  logic [15:0]                         velocity,
	input  logic                                allow_tail,
	input  logic signed [23:0]                  mix_left,
	input  logic signed [23:0]                  mix_right,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [23:0]                  out_left,
	output logic signed [23:0]                  out_right,
	output logic                                voice_active
);
	import spv_pkg::*;

	// configuration
	logic [6:0]  root_note_q;
	logic [23:0] rate_ratio_q;
	logic [16:0] sample_length_q;
	logic [15:0] ramp_on_q;
	logic [15:0] ramp_off_q;
	logic        stereo_source_q;
	logic        stereo_out_q;

	// voice state
	logic [POS_W-1:0]  pos_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0]       gain_q;
	logic [RAMP_W-1:0] ramp_q;
	logic [RAMP_W-1:0] atk_step_q;
	logic [REL_W-1:0]  rel_step_q;
	logic              in_attack_q;
	logic              in_release_q;
	logic              playing_q;

	state_t state_q, state_d;

	logic [3:0] semi_q;
	logic [4:0] shift_q;
	logic       ch_q;
	logic signed [BUS_W-1:0] mixl_q, mixr_q;
	logic signed [15:0] a_l_q, b_l_q, a_r_q, b_r_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [CHAN_W-1:0] g_q, l_res_q, r_res_q;

	logic                    out_valid_q;
	logic signed [BUS_W-1:0] out_left_q, out_right_q;
	logic                    voice_active_q;

	logic accept;
	logic out_free;
	cmd_t cmd_v;

	// shared units
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	div_req_t                 div_req;
	logic                     div_done;
	logic [STEP_W-1:0]        div_quot;

	logic [MEM_AW-1:0]          ram_raddr;
	logic [2*SAMPLE_BITS-1:0]   ram_rdata;
	logic                       ram_we;

	// sequencer datapath
	logic [IDX_W-1:0]           idx;
	logic [IDX_W:0]             idx_ext, idx_nxt;
	logic                       a_oob, b_oob;
	logic [FRAC_BITS-1:0]       frac;
	logic [FRAC_BITS:0]         w0;
	logic signed [15:0]         a_sel, b_sel;
	logic signed [PROD_W-1:0]   isum, l8_full, g_full, r_full;
	logic signed [CHAN_W-1:0]   l8, g_now, ch_res;
	logic [48:0]                step_sum, step_rnd, step_sh;
	logic [STEP_W-1:0]          step_new;
	logic                       ramped;

	// note-on pitch split
	logic signed [8:0] diff, oct9, semi9, sh9;
	logic [7:0]        dmag;
	logic [15:0]       dmul;

	// final step
	logic signed [CHAN_W:0]  lr_sum, lr_avg;
	logic signed [CHAN_W+1:0] sum_l, sum_r;
	logic signed [BUS_W-1:0] fin_l, fin_r;
	logic [RAMP_W:0]         atk_next;
	logic                    silenced;
	logic [POS_W:0]          pos_next;
	logic                    past_end;

	assign cmd_v    = cmd_t'(cmd);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	spv_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (prod)
	);

	spv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign ram_we = accept && (cmd_v == CMD_LOAD) && (load_addr < 17'(MEM_DEPTH));

	spv_ram #(
		.WIDTH (2 * SAMPLE_BITS),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_addr[MEM_AW-1:0]),
		.wdata ({load_left[SAMPLE_BITS-1:0], load_right[SAMPLE_BITS-1:0]}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Pitch split of note - root into octave and semitone; 171/2048 stands in for 1/12.
	always_comb begin
		diff = $signed({2'b00, note}) - $signed({2'b00, root_note_q});
		if (!diff[8]) begin
			dmag = diff[7:0];
		end else begin
			dmag = 8'(9'sd11 - diff);
		end
		dmul = 16'(dmag) * 16'd171;
		if (!diff[8]) begin
			oct9 = $signed({4'b0000, dmul[15:11]});
		end else begin
			oct9 = -$signed({4'b0000, dmul[15:11]});
		end
		semi9 = diff - oct9 * 9'sd12;
		sh9   = 9'sd19 - oct9;
	end

	// tick datapath
	assign idx     = pos_q[POS_W-1:FRAC_BITS];
	assign idx_ext = {1'b0, idx};
	assign idx_nxt = idx_ext + 1'b1;
	assign a_oob   = idx_ext >= (IDX_W+1)'(MEM_DEPTH);
	assign b_oob   = idx_nxt >= (IDX_W+1)'(MEM_DEPTH);
	assign frac    = pos_q[FRAC_BITS-1:0];
	assign w0      = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac};
	assign a_sel   = ch_q ? a_r_q : a_l_q;
	assign b_sel   = ch_q ? b_r_q : b_l_q;
	assign isum    = acc_q + prod + PROD_W'(32768);
	assign l8_full = isum >>> 16;
	assign l8      = l8_full[CHAN_W-1:0];
	assign g_full  = (prod + PROD_W'(16384)) >>> 15;
	assign g_now   = g_full[CHAN_W-1:0];
	assign r_full  = (prod + PROD_W'(4194304)) >>> 23;
	assign ramped  = in_attack_q || in_release_q;
	assign ch_res  = ramped ? r_full[CHAN_W-1:0] : g_q;

	assign step_rnd = 49'(1) << (shift_q - 5'd1);
	assign step_sum = {1'b0, prod[47:0]} + step_rnd;
	assign step_sh  = step_sum >> shift_q;
	assign step_new = (|step_sh[48:STEP_W]) ? '1 : step_sh[STEP_W-1:0];

	always_comb begin
		lr_sum = CHAN_W'(0) + {l_res_q[CHAN_W-1], l_res_q} + {r_res_q[CHAN_W-1], r_res_q};
		lr_avg = (lr_sum + $signed((CHAN_W+1)'(1))) >>> 1;
		if (stereo_out_q) begin
			sum_l = (CHAN_W+2)'(mixl_q) + (CHAN_W+2)'(l_res_q);
			sum_r = (CHAN_W+2)'(mixr_q) + (CHAN_W+2)'(r_res_q);
		end else begin
			sum_l = (CHAN_W+2)'(mixl_q) + (CHAN_W+2)'(lr_avg);
			sum_r = (CHAN_W+2)'(mixr_q);
		end
		if (sum_l > (CHAN_W+2)'(8388607)) begin
			fin_l = 24'sd8388607;
		end else if (sum_l < -(CHAN_W+2)'(8388608)) begin
			fin_l = -24'sd8388608;
		end else begin
			fin_l = sum_l[BUS_W-1:0];
		end
		if (sum_r > (CHAN_W+2)'(8388607)) begin
			fin_r = 24'sd8388607;
		end else if (sum_r < -(CHAN_W+2)'(8388608)) begin
			fin_r = -24'sd8388608;
		end else begin
			fin_r = sum_r[BUS_W-1:0];
		end
		atk_next = {1'b0, ramp_q} + {1'b0, atk_step_q};
		silenced = !in_attack_q && in_release_q && ({1'b0, ramp_q} <= rel_step_q);
		pos_next = {1'b0, pos_q} + (POS_W+1)'(step_q);
		past_end = pos_next > {sample_length_q, FRAC_BITS'(0)};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_v)
						CMD_NOTE_ON: state_d = ST_STEP_MUL;
						CMD_TICK:    state_d = playing_q ? ST_RD0 : ST_FIN;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_STEP_MUL: state_d = ST_STEP_RND;
			ST_STEP_RND: begin
				if (ramp_on_q != '0) begin
					state_d = ST_ATK_GO;
				end else if (ramp_off_q != '0) begin
					state_d = ST_REL_GO;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ATK_GO:   state_d = ST_ATK_WAIT;
			ST_ATK_WAIT: begin
				if (div_done) begin
					state_d = (ramp_off_q != '0) ? ST_REL_GO : ST_IDLE;
				end
			end
			ST_REL_GO:   state_d = ST_REL_WAIT;
			ST_REL_WAIT: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD0: state_d = ST_RD1;
			ST_RD1: state_d = ST_RD2;
			ST_RD2: state_d = ST_MA;
			ST_MA:  state_d = ST_MB;
			ST_MB:  state_d = ST_MG;
			ST_MG:  state_d = ST_MR;
			ST_MR:  state_d = ST_MD;
			ST_MD:  state_d = (!ch_q && stereo_source_q) ? ST_MA : ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mul_a            = '0;
		mul_b            = '0;
		ram_raddr        = idx[MEM_AW-1:0];
		div_req.start    = 1'b0;
		div_req.dividend = step_q;
		div_req.divisor  = {ramp_on_q, 1'b0};
		case (state_q)
			ST_STEP_MUL: begin
				mul_a = $signed({2'b00, rate_ratio_q});
				mul_b = $signed({2'b00, semitone_q23(semi_q)});
			end
			ST_ATK_GO: div_req.start = 1'b1;
			ST_REL_GO: begin
				div_req.start   = 1'b1;
				div_req.divisor = {ramp_off_q, 1'b0};
			end
			ST_RD1: ram_raddr = idx_nxt[MEM_AW-1:0];
			ST_MA: begin
				mul_a = MUL_W'(a_sel);
				mul_b = $signed({1'b0, w0});
			end
			ST_MB: begin
				mul_a = MUL_W'(b_sel);
				mul_b = $signed({2'b00, frac});
			end
			ST_MG: begin
				mul_a = MUL_W'(l8);
				mul_b = $signed({10'b0, gain_q});
			end
			ST_MR: begin
				mul_a = MUL_W'(g_now);
				mul_b = $signed({2'b00, ramp_q});
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// control and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			root_note_q     <= 7'd60;
			rate_ratio_q    <= 24'd1048576;
			sample_length_q <= '0;
			ramp_on_q       <= '0;
			ramp_off_q      <= '0;
			stereo_source_q <= 1'b1;
			stereo_out_q    <= 1'b1;
			pos_q           <= '0;
			step_q          <= '0;
			gain_q          <= '0;
			ramp_q          <= '0;
			atk_step_q      <= '0;
			rel_step_q      <= '0;
			in_attack_q     <= 1'b0;
			in_release_q    <= 1'b0;
			playing_q       <= 1'b0;
			ch_q            <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROOT_NOTE:     root_note_q     <= cfg_data[6:0];
					REG_RATE_RATIO:    rate_ratio_q    <= cfg_data[23:0];
					REG_SAMPLE_LENGTH: sample_length_q <= cfg_data[16:0];
					REG_RAMP_ON:       ramp_on_q       <= cfg_data[15:0];
					REG_RAMP_OFF:      ramp_off_q      <= cfg_data[15:0];
					REG_STEREO_SOURCE: stereo_source_q <= cfg_data[0];
					REG_STEREO_OUT:    stereo_out_q    <= cfg_data[0];
					default:           root_note_q     <= root_note_q;
				endcase
			end
			// The final step loads the next result itself when the register frees up.
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ch_q <= 1'b0;
					if (accept && cmd_v == CMD_NOTE_ON) begin
						pos_q        <= '0;
						gain_q       <= (velocity > 16'd32768) ? 16'd32768 : velocity;
						in_release_q <= 1'b0;
						in_attack_q  <= (ramp_on_q != '0);
						ramp_q       <= (ramp_on_q != '0) ? '0 : RAMP_UNITY;
						atk_step_q   <= '0;
						rel_step_q   <= REL_W'(RAMP_UNITY);
						playing_q    <= 1'b1;
					end else if (accept && cmd_v == CMD_NOTE_OFF) begin
						in_attack_q  <= 1'b0;
						in_release_q <= allow_tail;
						if (!allow_tail) begin
							playing_q <= 1'b0;
						end
					end
				end
				ST_STEP_RND: step_q <= step_new;
				ST_ATK_WAIT: begin
					if (div_done) begin
						atk_step_q <= (|div_quot[STEP_W-1:RAMP_W]) ? '1 : div_quot[RAMP_W-1:0];
					end
				end
				ST_REL_WAIT: begin
					if (div_done) begin
						rel_step_q <= (|div_quot[STEP_W-1:REL_W]) ? '1 : div_quot[REL_W-1:0];
					end
				end
				ST_MD: begin
					ch_q <= 1'b1;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (playing_q) begin
							if (in_attack_q) begin
								if (atk_next >= {1'b0, RAMP_UNITY}) begin
									ramp_q      <= RAMP_UNITY;
									in_attack_q <= 1'b0;
								end else begin
									ramp_q <= atk_next[RAMP_W-1:0];
								end
							end else if (in_release_q && !silenced) begin
								ramp_q <= RAMP_W'({1'b0, ramp_q} - rel_step_q);
							end
							if (silenced) begin
								playing_q    <= 1'b0;
								in_attack_q  <= 1'b0;
								in_release_q <= 1'b0;
							end else begin
								pos_q <= pos_next[POS_W-1:0];
								if (past_end) begin
									playing_q    <= 1'b0;
									in_attack_q  <= 1'b0;
									in_release_q <= 1'b0;
								end
							end
						end
					end
				end
				default: begin
					ch_q <= ch_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mixl_q  <= mix_left;
					mixr_q  <= mix_right;
					semi_q  <= semi9[3:0];
					shift_q <= sh9[4:0];
				end
			end
			ST_RD1: begin
				a_l_q <= a_oob ? '0 : 16'(signed'(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
				a_r_q <= a_oob ? '0 : 16'(signed'(ram_rdata[SAMPLE_BITS-1:0]));
			end
			ST_RD2: begin
				b_l_q <= b_oob ? '0 : 16'(signed'(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
				b_r_q <= b_oob ? '0 : 16'(signed'(ram_rdata[SAMPLE_BITS-1:0]));
			end
			ST_MB: acc_q <= prod;
			ST_MR: g_q <= g_now;
			ST_MD: begin
				if (!ch_q) begin
					l_res_q <= ch_res;
					r_res_q <= ch_res;
				end else begin
					r_res_q <= ch_res;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					// A silent or idle voice passes the mix through untouched.
					if (playing_q && !silenced) begin
						out_left_q  <= fin_l;
						out_right_q <= fin_r;
					end else begin
						out_left_q  <= mixl_q;
						out_right_q <= mixr_q;
					end
					voice_active_q <= playing_q && !silenced && !past_end;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_left     = out_left_q;
	assign out_right    = out_right_q;
	assign voice_active = voice_active_q;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the sampler voice core, with a built-in voice predictor.
`timescale 1ns / 100ps

module testbench;
	import spv_pkg::*;

	typedef struct {
		cmd_t        op;
		logic [16:0] addr;
		logic [15:0] ld_l;
		logic [15:0] ld_r;
		logic [6:0]  nt;
		logic [15:0] vel;
		logic        tail;
		logic [23:0] mx_l;
		logic [23:0] mx_r;
	} voice_cmd_s;

	typedef struct {
		logic [23:0] l;
		logic [23:0] r;
		logic        act;
	} mix_out_s;

	typedef struct {
		voice_cmd_s c;
		bit         typed;
		mix_out_s   o;
	} table_row_s;

	localparam int IDLE_LIMIT  = 3000;
	localparam int SETTLE      = 120;
	localparam int N_ITEMS     = 550;
	localparam longint BUS_MAX = 8388607;
	localparam longint BUS_MIN = -8388608;
	localparam longint unsigned UNITY = 8388608;
	localparam longint unsigned SEMI [12] = '{8388608, 8887421, 9415894, 9975792,
		10568984, 11197448, 11863283, 12568711, 13316085, 14107901, 14946800, 15835583};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [16:0] load_addr = '0;
	logic signed [15:0] load_left = '0;
	logic signed [15:0] load_right = '0;
	logic [6:0] note = '0;
	logic [15:0] velocity = '0;
	logic allow_tail = 1'b0;
	logic signed [23:0] mix_left = '0;
	logic signed [23:0] mix_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [23:0] out_left;
	logic signed [23:0] out_right;
	logic voice_active;

	sample_playback_voice_core DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state and shadow configuration.
	logic signed [15:0] left_mem [int];
	logic signed [15:0] right_mem [int];
	longint unsigned pos, step;
	longint unsigned gain, level, atk_step, rel_step;
	bit in_atk, in_rel, sounding;
	int unsigned root, rate, slen, ron, roff;
	bit src_stereo, out_stereo;

	mix_out_s pending_mix [$];
	int mismatches = 0;
	int sent = 0;
	bit quiet = 0;

	function automatic longint rnd_shift(longint x, int n);
		if (n <= 0)
			return x;
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint sat_bus(longint v);
		if (v > BUS_MAX) return BUS_MAX;
		if (v < BUS_MIN) return BUS_MIN;
		return v;
	endfunction

	function automatic longint tap(bit right, longint unsigned i);
		if (i >= MEM_DEPTH)
			return 0;
		return right ? longint'(right_mem[int'(i)]) : longint'(left_mem[int'(i)]);
	endfunction

	function automatic longint lerp(bit right, longint unsigned i, longint f);
		return rnd_shift(tap(right, i) * ((longint'(1) << 24) - f) + tap(right, i + 1) * f, 16);
	endfunction

	function automatic longint scale_out(longint s, bit ramped);
		longint g;
		g = rnd_shift(s * longint'(gain), 15);
		if (ramped)
			g = rnd_shift(g * longint'(level), 23);
		return g;
	endfunction

	function automatic longint unsigned ramp_rate(int unsigned len, longint unsigned maxv);
		longint unsigned q;
		q = step / (2 * longint'(len));
		return q > maxv ? maxv : q;
	endfunction

	function automatic void silence();
		sounding = 0;
		in_atk = 0;
		in_rel = 0;
	endfunction

	// Advances the predicted voice by one command; returns 1 when it gives a mix result.
	function automatic bit advance_voice(voice_cmd_s c, output mix_out_s o);
		int diff, oct, semi, sh;
		longint unsigned p, idx;
		longint ml, mr, ol, orr, l8, r8, l, r, f;
		bit ramped, muted;
		ml = longint'($signed(c.mx_l));
		mr = longint'($signed(c.mx_r));
		ol = ml;
		orr = mr;
		case (c.op)
			CMD_LOAD: begin
				if (c.addr < MEM_DEPTH) begin
					left_mem[int'(c.addr)] = c.ld_l;
					right_mem[int'(c.addr)] = c.ld_r;
				end
				return 0;
			end
			CMD_NOTE_ON: begin
				diff = int'(c.nt) - int'(root);
				oct = diff >= 0 ? diff / 12 : -((11 - diff) / 12);
				semi = diff - 12 * oct;
				sh = 19 - oct;
				p = longint'(rate) * SEMI[semi];
				p = (p + (longint'(1) << (sh - 1))) >> sh;
				step = p > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : p;
				pos = 0;
				gain = c.vel > 32768 ? 32768 : c.vel;
				in_rel = 0;
				in_atk = ron > 0;
				if (in_atk) begin
					level = 0;
					atk_step = ramp_rate(ron, 24'hFF_FFFF);
				end else begin
					level = UNITY;
					atk_step = 0;
				end
				rel_step = roff > 0 ? ramp_rate(roff, 25'h1FF_FFFF) : UNITY;
				sounding = 1;
				return 0;
			end
			CMD_NOTE_OFF: begin
				if (c.tail) begin
					in_atk = 0;
					in_rel = 1;
				end else begin
					silence();
				end
				return 0;
			end
			default: ;
		endcase
		if (sounding) begin
			idx = pos >> 24;
			f = longint'(pos & 64'hFF_FFFF);
			l8 = lerp(0, idx, f);
			r8 = src_stereo ? lerp(1, idx, f) : l8;
			ramped = in_atk || in_rel;
			l = scale_out(l8, ramped);
			r = scale_out(r8, ramped);
			muted = 0;
			if (in_atk) begin
				level = level + atk_step;
				if (level >= UNITY) begin
					level = UNITY;
					in_atk = 0;
				end
			end else if (in_rel) begin
				if (level <= rel_step) begin
					silence();
					muted = 1;
				end else begin
					level = level - rel_step;
				end
			end
			if (!muted) begin
				if (out_stereo) begin
					ol = sat_bus(ml + l);
					orr = sat_bus(mr + r);
				end else begin
					ol = sat_bus(ml + rnd_shift(l + r, 1));
				end
				pos = pos + step;
				if (pos > (longint'(slen) << 24))
					silence();
			end
		end
		o.l = ol[23:0];
		o.r = orr[23:0];
		o.act = sounding;
		return 1;
	endfunction

	function automatic voice_cmd_s mk(cmd_t op, logic [16:0] a, logic [15:0] ll, logic [15:0] lr,
			logic [6:0] n, logic [15:0] v, logic t, logic [23:0] xl, logic [23:0] xr);
		voice_cmd_s c;
		c.op = op; c.addr = a; c.ld_l = ll; c.ld_r = lr; c.nt = n;
		c.vel = v; c.tail = t; c.mx_l = xl; c.mx_r = xr;
		return c;
	endfunction

	function automatic logic [23:0] rand_mix();
		case ($urandom_range(0, 7))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2: return 24'h00_0000;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic voice_cmd_s rand_fields(cmd_t op);
		return mk(op, 17'($urandom()), 16'($urandom()), 16'($urandom()), 7'($urandom()),
			16'($urandom()), 1'($urandom()), rand_mix(), rand_mix());
	endfunction

	// Drives one command and returns once its transfer has happened.
	task automatic drive_cmd(voice_cmd_s c);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		cmd = c.op;
		load_addr = c.addr;
		load_left = c.ld_l;
		load_right = c.ld_r;
		note = c.nt;
		velocity = c.vel;
		allow_tail = c.tail;
		mix_left = c.mx_l;
		mix_right = c.mx_r;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic issue(voice_cmd_s c, bit typed = 0, mix_out_s want = '{0, 0, 0});
		mix_out_s o;
		if (advance_voice(c, o))
			pending_mix.push_back(typed ? want : o);
		sent++;
		drive_cmd(c);
	endtask

	// A tick may only read sample words that were loaded, so missing taps are loaded first.
	task automatic issue_tick(voice_cmd_s c);
		longint unsigned a;
		if (sounding) begin
			for (int k = 0; k < 2; k++) begin
				a = (pos >> 24) + k;
				if (a < MEM_DEPTH && !left_mem.exists(int'(a)))
					issue(mk(CMD_LOAD, a[16:0], 16'($urandom()), 16'($urandom()),
						0, 0, 0, 0, 0));
			end
		end
		issue(c);
	endtask

	task automatic write_reg(cfg_reg_t r, int unsigned v);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_write = 1'b1;
		cfg_index = r;
		cfg_data = CFG_DATA_W'(v);
		case (r)
			REG_ROOT_NOTE:     root = v & 32'h7F;
			REG_RATE_RATIO:    rate = v & 32'hFF_FFFF;
			REG_SAMPLE_LENGTH: slen = v & 32'h1_FFFF;
			REG_RAMP_ON:       ron = v & 32'hFFFF;
			REG_RAMP_OFF:      roff = v & 32'hFFFF;
			REG_STEREO_SOURCE: src_stereo = v[0];
			REG_STEREO_OUT:    out_stereo = v[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Result side: random stall bursts, then a compare on every transfer.
	initial begin
		int n;
		forever begin
			n = $urandom_range(1, 12);
			@(negedge clk);
			out_stall = quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
			repeat (n - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		mix_out_s e;
		if (out_valid && !out_stall) begin
			if (pending_mix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: left %0d right %0d active %0b",
						out_left, out_right, voice_active);
			end else begin
				e = pending_mix.pop_front();
				if (out_left !== e.l || out_right !== e.r || voice_active !== e.act) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %0d %0d %0b, got %0d %0d %0b",
							$signed(e.l), $signed(e.r), e.act,
							out_left, out_right, voice_active);
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				idle = 0;
			else
				idle++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		table_row_s rows [$];
		table_row_s row;
		voice_cmd_s c;
		int unsigned pick;
		int per_phase;
		int phase_end;
		root = 60; rate = 1048576; slen = 0; ron = 0; roff = 0;
		src_stereo = 1; out_stereo = 1;
		pos = 0; step = 0; gain = 0; level = 0; atk_step = 0; rel_step = 0;
		silence();

		// Directed table: typed results only for ticks on an idle voice.
		row.typed = 1;
		row.c = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 24'h7F_FFFF, 24'h7F_FFFF);
		row.o = '{24'h7F_FFFF, 24'h7F_FFFF, 0};
		rows.push_back(row);
		row.c = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 24'h80_0000, 24'h80_0000);
		row.o = '{24'h80_0000, 24'h80_0000, 0};
		rows.push_back(row);
		row.typed = 0;
		row.c = mk(CMD_LOAD, 0, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0); rows.push_back(row);
		row.c = mk(CMD_LOAD, 1, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0); rows.push_back(row);
		row.c = mk(CMD_LOAD, 2, 16'hFFFF, 16'h0001, 0, 0, 0, 0, 0); rows.push_back(row);
		row.c = mk(CMD_LOAD, 17'(MEM_DEPTH - 1), 16'h1234, 16'hEDCB, 0, 0, 0, 0, 0);
		rows.push_back(row);
		// Loads beyond the memory depth are dropped.
		row.c = mk(CMD_LOAD, 17'(MEM_DEPTH), 16'h5555, 16'hAAAA, 0, 0, 0, 0, 0);
		rows.push_back(row);
		row.c = mk(CMD_LOAD, 17'h1_FFFF, 16'hAAAA, 16'h5555, 0, 0, 0, 0, 0); rows.push_back(row);
		// A note-off on an idle voice has no audible effect.
		row.c = mk(CMD_NOTE_OFF, 0, 0, 0, 0, 0, 1, 0, 0); rows.push_back(row);
		row.typed = 1;
		row.c = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 24'h12_3456, 24'hED_CBA9);
		row.o = '{24'h12_3456, 24'hED_CBA9, 0};
		rows.push_back(row);
		row.typed = 0;
		// Velocity above unity saturates; the end is passed on the first tick.
		row.c = mk(CMD_NOTE_ON, 0, 0, 0, 60, 16'hFFFF, 0, 0, 0); rows.push_back(row);
		row.c = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 24'h7F_0000, 24'h80_FFFF); rows.push_back(row);
		row.c = mk(CMD_NOTE_ON, 0, 0, 0, 0, 16'd0, 0, 0, 0); rows.push_back(row);
		row.c = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 24'h00_1000, 24'h00_2000); rows.push_back(row);
		row.c = mk(CMD_NOTE_ON, 0, 0, 0, 127, 16'd32768, 0, 0, 0); rows.push_back(row);
		row.c = mk(CMD_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
		row.typed = 1;
		row.c = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 24'h00_0001, 24'hFF_FFFF);
		row.o = '{24'h00_0001, 24'hFF_FFFF, 0};
		rows.push_back(row);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].c.op == CMD_TICK && !rows[i].typed)
				issue_tick(rows[i].c);
			else
				issue(rows[i].c, rows[i].typed, rows[i].o);
		end

		// Tap loads count toward the total, so each phase runs to an item budget.
		per_phase = (N_ITEMS - sent) / 7;
		for (int ph = 0; ph < 7; ph++) begin
			@(negedge clk);
			in_valid = 1'b0;
			wait (pending_mix.size() == 0);
			repeat (SETTLE) @(posedge clk);
			case (ph)
				0: begin
					write_reg(REG_ROOT_NOTE, 0); write_reg(REG_RATE_RATIO, 24'hFF_FFFF);
					write_reg(REG_SAMPLE_LENGTH, 65536); write_reg(REG_RAMP_ON, 0);
					write_reg(REG_RAMP_OFF, 0); write_reg(REG_STEREO_SOURCE, 1);
					write_reg(REG_STEREO_OUT, 1);
				end
				1: begin
					write_reg(REG_ROOT_NOTE, 127); write_reg(REG_RATE_RATIO, 0);
					write_reg(REG_SAMPLE_LENGTH, 0); write_reg(REG_RAMP_ON, 65535);
					write_reg(REG_RAMP_OFF, 65535); write_reg(REG_STEREO_SOURCE, 0);
					write_reg(REG_STEREO_OUT, 0);
				end
				2: begin
					write_reg(REG_ROOT_NOTE, 60); write_reg(REG_RATE_RATIO, 1048576);
					write_reg(REG_SAMPLE_LENGTH, 200); write_reg(REG_RAMP_ON, 8);
					write_reg(REG_RAMP_OFF, 6); write_reg(REG_STEREO_SOURCE, 1);
					write_reg(REG_STEREO_OUT, 0);
				end
				default: begin
					write_reg(REG_ROOT_NOTE, $urandom_range(0, 127));
					write_reg(REG_RATE_RATIO, $urandom_range(0, 3) == 0 ? $urandom()
						: $urandom_range(200000, 3000000));
					write_reg(REG_SAMPLE_LENGTH, $urandom_range(1, 300));
					write_reg(REG_RAMP_ON, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40));
					write_reg(REG_RAMP_OFF, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40));
					write_reg(REG_STEREO_SOURCE, $urandom_range(0, 1));
					write_reg(REG_STEREO_OUT, $urandom_range(0, 1));
				end
			endcase
			phase_end = sent + per_phase;
			while (sent < phase_end) begin
				if (ph == 6 && sent > phase_end - 40)
					quiet = 1;
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					c = rand_fields(CMD_LOAD);
					// Mostly low addresses, some near and beyond the top of memory.
					if ($urandom_range(0, 3) != 0)
						c.addr = 17'($urandom_range(0, 400));
					else if ($urandom_range(0, 1) == 0)
						c.addr = 17'($urandom_range(65530, 65545));
					issue(c);
				end else if (pick < 18 || !sounding && pick < 40) begin
					issue(rand_fields(CMD_NOTE_ON));
				end else if (pick < 24) begin
					c = rand_fields(CMD_NOTE_OFF);
					c.tail = $urandom_range(0, 3) != 0;
					issue(c);
				end else begin
					issue_tick(rand_fields(CMD_TICK));
				end
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_mix.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
